// ----- sv/lph_pkg.sv -----
package lph_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 1024;

	localparam int unsigned KEY_W = 31;
	localparam int unsigned VAL_W = 31;
	localparam int unsigned SLOT_W = 32;

	localparam logic [SLOT_W-1:0] HASH_MULT   = 32'd2654435761;
	localparam logic [SLOT_W-1:0] KEY_EMPTY   = 32'hFFFF_FFFF;
	localparam logic [SLOT_W-1:0] KEY_REMOVED = 32'hFFFF_FFFE;

	// operation codes
	localparam logic [1:0] FN_INSERT  = 2'd0;
	localparam logic [1:0] FN_REPLACE = 2'd1;
	localparam logic [1:0] FN_REMOVE  = 2'd2;

	// result codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

endpackage

// ----- sv/lph_ram.sv -----
module lph_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/lph_hash.sv -----
module lph_hash #(
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic [lph_pkg::KEY_W-1:0] key,
	output logic [AW-1:0]             home
);

	import lph_pkg::*;

	logic [SLOT_W-1:0] prod;

	// multiplicative hash, product taken mod 2^32
	assign prod = SLOT_W'({1'b0, key} * HASH_MULT);
	assign home = prod[AW-1:0] & AW'(DEPTH - 1);

endmodule

// ----- sv/linear_probe_hash_table_core.sv -----
// Flow: a taken input beat passes through the hash, probe and finish states, reading
//   one slot per cycle from the key memory while probing; a refused insert or an
//   unknown op skips the probe. No new beat is taken until the result is registered.
// Reset: arst_n clears control state at once, then a clearing pass writes every slot
//   of the key memory to empty while in_stall is held high.
module linear_probe_hash_table_core #(
	parameter int unsigned TABLE_DEPTH = lph_pkg::TABLE_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                func,
	input  logic [lph_pkg::KEY_W-1:0] key,
	input  logic [lph_pkg::VAL_W-1:0] value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                status,
	output logic [lph_pkg::VAL_W-1:0] old_value
);

	import lph_pkg::*;

	localparam int unsigned AW    = $clog2(TABLE_DEPTH);
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
	// an insert is refused once the count has reached two thirds of the size
	localparam logic [CNT_W-1:0] LOAD_LIMIT = CNT_W'(2 * TABLE_DEPTH / 3);
	localparam logic [AW-1:0]    LAST_SLOT  = AW'(TABLE_DEPTH - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_PROBE,
		S_FINISH
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      clr_q;      // clearing pass pointer
	logic [AW-1:0]      idx_q;      // slot whose read data is in flight
	logic [AW-1:0]      nprobe_q;   // slots probed so far, minus the current one
	logic [CNT_W-1:0]   used_q;
	logic [1:0]         func_q;
	logic [KEY_W-1:0]   key_q;
	logic [VAL_W-1:0]   value_q;
	logic [1:0]         res_status_q;
	logic [VAL_W-1:0]   res_old_q;
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [VAL_W-1:0]   old_value_q;

	// memory ports
	logic [AW-1:0]      home;
	logic [AW-1:0]      nxt_idx;
	logic [AW-1:0]      rd_addr;
	logic               kmem_we;
	logic [AW-1:0]      kmem_waddr;
	logic [SLOT_W-1:0]  kmem_wdata;
	logic [SLOT_W-1:0]  kmem_rdata;
	logic               vmem_we;
	logic [VAL_W-1:0]   vmem_rdata;

	// probe decode of the slot just read
	logic               slot_free;
	logic               slot_empty;
	logic               slot_hit;
	logic               last_probe;
	logic               in_beat;
	logic               out_free;

	lph_hash #(.DEPTH(TABLE_DEPTH)) u_hash (
		.key  (key_q),
		.home (home)
	);

	assign nxt_idx    = (idx_q == LAST_SLOT) ? '0 : idx_q + AW'(1);
	assign slot_empty = (kmem_rdata == KEY_EMPTY);
	assign slot_free  = slot_empty || (kmem_rdata == KEY_REMOVED);
	assign slot_hit   = (kmem_rdata == {1'b0, key_q});
	assign last_probe = (nprobe_q == LAST_SLOT);

	// home slot is read in the hash cycle; each probe cycle prefetches the next slot
	assign rd_addr = (state_q == S_HASH) ? home : nxt_idx;

	// clearing aside, writes land only when a probe ends, so the next op's reads see them
	always_comb begin
		kmem_we    = 1'b0;
		kmem_waddr = idx_q;
		kmem_wdata = {1'b0, key_q};
		vmem_we    = 1'b0;
		case (state_q)
			S_CLEAR: begin
				kmem_we    = 1'b1;
				kmem_waddr = clr_q;
				kmem_wdata = KEY_EMPTY;
			end
			S_PROBE: begin
				case (func_q)
					FN_INSERT: begin
						kmem_we = slot_free;
						vmem_we = slot_free;
					end
					FN_REPLACE: begin
						vmem_we = slot_hit;
					end
					FN_REMOVE: begin
						kmem_we    = slot_hit;
						kmem_wdata = KEY_REMOVED;
					end
					default: begin
						kmem_we = 1'b0;
					end
				endcase
			end
			default: begin
				kmem_we = 1'b0;
			end
		endcase
	end

	lph_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_DEPTH)) u_key_mem (
		.clk   (clk),
		.we    (kmem_we),
		.waddr (kmem_waddr),
		.wdata (kmem_wdata),
		.raddr (rd_addr),
		.rdata (kmem_rdata)
	);

	// value store is never cleared: it is only read behind a key match
	lph_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_val_mem (
		.clk   (clk),
		.we    (vmem_we),
		.waddr (idx_q),
		.wdata (value_q),
		.raddr (rd_addr),
		.rdata (vmem_rdata)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign in_beat   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign old_value = old_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			idx_q        <= '0;
			nprobe_q     <= '0;
			used_q       <= '0;
			out_valid_q  <= 1'b0;
			func_q       <= FN_INSERT;
			key_q        <= '0;
			value_q      <= '0;
			res_status_q <= ST_OK;
			res_old_q    <= '0;
			status_q     <= ST_OK;
			old_value_q  <= '0;
		end else begin
			// a waiting result leaves on its beat; in the finish state the next
			// result takes its place below
			if (out_valid_q && !out_stall && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_SLOT) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_beat) begin
						func_q  <= func;
						key_q   <= key;
						value_q <= value;
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					idx_q     <= home;
					nprobe_q  <= '0;
					res_old_q <= '0;
					if (func_q == FN_INSERT && used_q >= LOAD_LIMIT) begin
						res_status_q <= ST_FULL;
						state_q      <= S_FINISH;
					end else if (func_q != FN_INSERT && func_q != FN_REPLACE &&
					             func_q != FN_REMOVE) begin
						res_status_q <= ST_NOT_FOUND;
						state_q      <= S_FINISH;
					end else begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					idx_q    <= nxt_idx;
					nprobe_q <= nprobe_q + AW'(1);
					if (func_q == FN_INSERT) begin
						if (slot_free) begin
							used_q       <= used_q + CNT_W'(1);
							res_status_q <= ST_OK;
							state_q      <= S_FINISH;
						end else if (last_probe) begin
							res_status_q <= ST_FULL;
							state_q      <= S_FINISH;
						end
					end else if (slot_hit) begin
						res_status_q <= ST_OK;
						if (func_q == FN_REMOVE) begin
							res_old_q <= vmem_rdata;
							if (used_q != '0) begin
								used_q <= used_q - CNT_W'(1);
							end
						end
						state_q <= S_FINISH;
					end else if (slot_empty || last_probe) begin
						res_status_q <= ST_NOT_FOUND;
						state_q      <= S_FINISH;
					end
				end
				S_FINISH: begin
					// output register parts the two sides; wait only if it is still held
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						old_value_q <= res_old_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- sv/lph_checker.sv -----
module lph_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic [1:0]                func,
	input logic [lph_pkg::KEY_W-1:0] key,
	input logic [lph_pkg::VAL_W-1:0] value,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [1:0]                status,
	input logic [lph_pkg::VAL_W-1:0] old_value
);

	import lph_pkg::*;

	// clearing pass holds off input right after reset
	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> in_stall)
		else $error("input taken during clearing pass");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_NOT_FOUND || status == ST_FULL))
		else $error("bad status code");

	a_old_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> old_value == '0)
		else $error("old_value nonzero on failed op");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(func) && $stable(key) && $stable(value))
		else $error("input beat changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(old_value))
		else $error("result beat changed while stalled");

endmodule

bind linear_probe_hash_table_core lph_checker u_lph_checker (.*);

// ----- test/linear_probe_hash_table_core_tb.sv -----
`timescale 1ns / 1ps

module linear_probe_hash_table_core_tb;
	import lph_pkg::*;

	localparam int unsigned DEPTH      = TABLE_DEPTH_DEF;
	// inserts are refused once the live count would pass two thirds of the slots
	localparam int unsigned LOAD_LIMIT = 2 * DEPTH / 3;
	// func encoding the block does not decode; it answers not-found
	localparam logic [1:0] FN_UNKNOWN  = 2'd3;
	localparam logic [KEY_W-1:0] KEY_MAX = '1;
	localparam logic [VAL_W-1:0] VAL_MAX = '1;
	localparam int unsigned POOL_SIZE  = 48;
	localparam int unsigned PRINT_CAP  = 100;

	// one expected answer, tagged with the request that caused it
	typedef struct {
		logic [1:0]       op;
		logic [KEY_W-1:0] key;
		logic [1:0]       status;
		logic [VAL_W-1:0] old_value;
	} table_reply_t;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	// Shadow copy of the slot store plus the queue of answers still owed by the block.
	class slot_table_model;
		logic [SLOT_W-1:0] slot_key [DEPTH];
		logic [VAL_W-1:0]  slot_val [DEPTH];
		int unsigned       live;
		table_reply_t      awaited [$];
		int unsigned       mismatches;
		int unsigned       replies_seen;

		function new();
			for (int i = 0; i < DEPTH; i++) begin
				slot_key[i] = KEY_EMPTY;
				slot_val[i] = '0;
			end
			live = 0;
			mismatches = 0;
			replies_seen = 0;
		endfunction

		// Fibonacci hash: low bits of key * golden-ratio constant, product kept to 32 bits
		function int unsigned home_of(logic [KEY_W-1:0] k);
			logic [SLOT_W-1:0] h;
			h = {1'b0, k} * HASH_MULT;
			return h & (DEPTH - 1);
		endfunction

		// first slot holding k; stops at an empty slot, steps over removed ones
		function int probe_match(logic [KEY_W-1:0] k);
			int unsigned idx;
			idx = home_of(k);
			for (int n = 0; n < DEPTH; n++) begin
				if (slot_key[idx] == {1'b0, k})
					return idx;
				if (slot_key[idx] == KEY_EMPTY)
					return -1;
				idx = (idx + 1) % DEPTH;
			end
			return -1;
		endfunction

		function table_reply_t apply_op(logic [1:0] op, logic [KEY_W-1:0] k,
				logic [VAL_W-1:0] v);
			table_reply_t r;
			int unsigned  idx;
			int           hit;
			bit           placed;
			r.op = op;
			r.key = k;
			r.status = ST_NOT_FOUND;
			r.old_value = '0;
			case (op)
				FN_INSERT: begin
					r.status = ST_FULL;
					placed = 1'b0;
					if (live + 1 <= LOAD_LIMIT) begin
						idx = home_of(k);
						for (int n = 0; n < DEPTH && !placed; n++) begin
							if (slot_key[idx] == KEY_EMPTY || slot_key[idx] == KEY_REMOVED) begin
								slot_key[idx] = {1'b0, k};
								slot_val[idx] = v;
								live++;
								r.status = ST_OK;
								placed = 1'b1;
							end
							idx = (idx + 1) % DEPTH;
						end
					end
				end
				FN_REPLACE: begin
					hit = probe_match(k);
					if (hit >= 0) begin
						slot_val[hit] = v;
						r.status = ST_OK;
					end
				end
				FN_REMOVE: begin
					hit = probe_match(k);
					if (hit >= 0) begin
						slot_key[hit] = KEY_REMOVED;
						r.old_value = slot_val[hit];
						if (live > 0)
							live--;
						r.status = ST_OK;
					end
				end
				default: begin
				end
			endcase
			return r;
		endfunction

		function void note_request(logic [1:0] op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
			awaited.push_back(apply_op(op, k, v));
		endfunction

		task flag_mismatch(string what);
			mismatches++;
			if (mismatches <= PRINT_CAP)
				$display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_response(logic [1:0] st, logic [VAL_W-1:0] old);
			table_reply_t want;
			replies_seen++;
			if (awaited.size() == 0) begin
				flag_mismatch($sformatf("reply %0d with nothing pending (status %0d old_value %0h)",
					replies_seen, st, old));
				return;
			end
			want = awaited.pop_front();
			if (st !== want.status)
				flag_mismatch($sformatf("reply %0d op %0d key %0h: status %0d, want %0d",
					replies_seen, want.op, want.key, st, want.status));
			if (old !== want.old_value)
				flag_mismatch($sformatf("reply %0d op %0d key %0h: old_value %0h, want %0h",
					replies_seen, want.op, want.key, old, want.old_value));
		endtask
	endclass

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	logic [1:0]       func      = FN_INSERT;
	logic [KEY_W-1:0] key       = '0;
	logic [VAL_W-1:0] value     = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [1:0]       status;
	logic [VAL_W-1:0] old_value;

	slot_table_model sb = new();

	// sender pacing: beats left in the current burst
	int unsigned burst_left = 0;
	// receiver pacing
	int unsigned stall_tick = 0;
	stall_mode_t stall_mode = STALL_NONE;

	// Keys that share low 10 bits land on the same home slot, so this pool
	// builds long probe chains, duplicates and removed-slot runs.
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	linear_probe_hash_table_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.key       (key),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.old_value (old_value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop. Worst legal pace is roughly a full-table probe per beat plus
	// sender gaps and receiver stalls; this allows about four times that.
	initial begin
		#40ms;
		$display("linear_probe_hash_table_core_tb: done, errors");
		$finish;
	end

	// Receiver: a result beat is taken on any edge with out_valid high and
	// out_stall low. Values are read before this edge's updates land, so the
	// check sees exactly what the block presented. The stall pattern changes
	// flavor over time, including stretches with no stall at all.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_response(status, old_value);
		stall_tick <= stall_tick + 1;
		if (stall_tick % 97 == 0)
			stall_mode <= stall_mode_t'($urandom_range(3));
		case (stall_mode)
			STALL_NONE:     out_stall <= 1'b0;
			STALL_LIGHT:    out_stall <= ($urandom_range(3) == 0);
			STALL_HEAVY:    out_stall <= ($urandom_range(3) != 0);
			default:        out_stall <= (stall_tick % 5 < 3);
		endcase
	end

	// Sender idling: bursts of random length, random gaps between them.
	// Roughly one burst in four is long, giving back-to-back stretches.
	task automatic pace();
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
		end
	endtask

	// Present one request beat and hold it until taken; the model is
	// updated on the accepting edge, so it always tracks the block's order.
	task automatic send_op(logic [1:0] op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
		pace();
		in_valid <= 1'b1;
		func     <= op;
		key      <= k;
		value    <= v;
		do @(posedge clk); while (in_stall);
		sb.note_request(op, k, v);
		burst_left--;
	endtask

	// Sender holds off until every answer owed has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.awaited.size() != 0);
	endtask

	function automatic logic [KEY_W-1:0] pick_key(int unsigned pool_pct);
		logic [KEY_W-1:0] k;
		if ($urandom_range(99) < pool_pct)
			k = key_pool[$urandom_range(POOL_SIZE - 1)];
		else
			k = KEY_W'($urandom);
		return k;
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		logic [VAL_W-1:0] v;
		case ($urandom_range(9))
			0:       v = '0;
			1:       v = VAL_MAX;
			default: v = VAL_W'($urandom);
		endcase
		return v;
	endfunction

	// One random request; the percentages split insert / replace / remove,
	// whatever is left over goes to the undecoded func.
	task automatic random_op(int unsigned ins_pct, int unsigned rep_pct,
			int unsigned rem_pct, int unsigned pool_pct);
		int unsigned roll;
		logic [1:0]  op;
		roll = $urandom_range(99);
		if (roll < ins_pct)
			op = FN_INSERT;
		else if (roll < ins_pct + rep_pct)
			op = FN_REPLACE;
		else if (roll < ins_pct + rep_pct + rem_pct)
			op = FN_REMOVE;
		else
			op = FN_UNKNOWN;
		send_op(op, pick_key(pool_pct), pick_value());
	endtask

	initial begin
		logic [9:0]       home_bits [8];
		logic [KEY_W-1:0] c0;
		logic [KEY_W-1:0] c1;
		logic [KEY_W-1:0] c2;
		logic [KEY_W-1:0] c3;
		logic [20:0]      upper;

		for (int j = 0; j < 8; j++)
			home_bits[j] = 10'($urandom);
		for (int i = 0; i < POOL_SIZE; i++) begin
			upper = 21'($urandom);
			key_pool[i] = {upper, home_bits[i % 8]};
		end

		// four keys on one home slot (same low 10 bits)
		c0 = 31'h0000_0155;
		c1 = c0 + 31'd1024;
		c2 = c0 + 31'd2048;
		c3 = c0 + 31'd3072;

		// reset is held, then released; the block then clears its key store on its own,
		// holding in_stall high, which the first send simply waits out
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// ---- directed part ----
		// lookups on an empty table stop at the first empty slot
		send_op(FN_REMOVE,  '0,      '0);
		send_op(FN_REPLACE, KEY_MAX, VAL_MAX);
		// extreme keys and values
		send_op(FN_INSERT,  '0,      '0);
		send_op(FN_INSERT,  KEY_MAX, VAL_MAX);
		// a good replace answers old_value zero
		send_op(FN_REPLACE, '0,      VAL_MAX);
		send_op(FN_REMOVE,  KEY_MAX, '0);
		// second remove steps over the removed slot, then hits empty
		send_op(FN_REMOVE,  KEY_MAX, VAL_MAX);
		// duplicate key: removes take copies in probe order
		send_op(FN_INSERT,  '0,      31'd5);
		send_op(FN_REMOVE,  '0,      '0);
		send_op(FN_REMOVE,  '0,      '0);
		// undecoded func, both bits of the field high
		send_op(FN_UNKNOWN, KEY_MAX, VAL_MAX);
		send_op(FN_UNKNOWN, '0,      '0);
		// collision chain, a hole in the middle, and reuse of that hole
		send_op(FN_INSERT,  c0, 31'h2AAA_AAAA);
		send_op(FN_INSERT,  c1, 31'h5555_5555);
		send_op(FN_INSERT,  c2, 31'd3);
		send_op(FN_REMOVE,  c1, '0);
		send_op(FN_REPLACE, c2, 31'h1234_5678);
		send_op(FN_INSERT,  c3, 31'd7);
		send_op(FN_REMOVE,  c1, '0);
		send_op(FN_REMOVE,  c2, '0);
		send_op(FN_REPLACE, c0, '0);
		send_op(FN_REMOVE,  c3, VAL_MAX);
		send_op(FN_REMOVE,  c0, '0);
		drain_results();

		// ---- random: mixed traffic on a lightly loaded table ----
		repeat (100)
			random_op(50, 20, 25, 75);
		drain_results();

		// ---- random: fill to the load limit, then push against it ----
		while (sb.live < LOAD_LIMIT)
			random_op(85, 10, 5, 40);
		repeat (30)
			random_op(70, 10, 15, 50);
		drain_results();

		// ---- random: drain-heavy mix over long chains and removed runs ----
		repeat (50)
			random_op(20, 25, 45, 80);

		// wait for the last answers, then a short quiet window for strays
		drain_results();
		repeat (32) @(posedge clk);

		if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
			$display("linear_probe_hash_table_core_tb: done, clean");
		end else begin
			$display("linear_probe_hash_table_core_tb: done, errors");
		end
		$finish;
	end

endmodule
